// File: hw/rtl/swack_pkg.sv
// ----------------------------------------------------------------------------
// swack_pkg - shared definitions for the sliding window ack sender
// Send kinds, register map, window limit, sequencer states and alu operand type.
// ----------------------------------------------------------------------------
package swack_pkg;

	localparam int unsigned MAX_WINDOW = 64;
	localparam int unsigned CNT_W      = $clog2(MAX_WINDOW + 1);

	localparam logic [2:0] KIND_BEGIN = 3'd0;
	localparam logic [2:0] KIND_DATA  = 3'd1;
	localparam logic [2:0] KIND_END   = 3'd2;
	localparam logic [2:0] KIND_FIN   = 3'd3;
	localparam logic [2:0] KIND_DONE  = 3'd4;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_LAST   = 2'd1;
	localparam logic [1:0] REG_STORED = 2'd2;
	localparam logic [1:0] REG_WINDOW = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T1,
		ST_S,
		ST_LP1,
		ST_D,
		ST_DEC,
		ST_WMIN,
		ST_ENDSEQ,
		ST_W1,
		ST_W2,
		ST_W3,
		ST_W4,
		ST_W5,
		ST_W6,
		ST_W7,
		ST_W8,
		ST_DSEQ,
		ST_DINC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_op_t;

endpackage

// File: hw/rtl/sliding_window_ack_sender_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_ack_sender_unit - go-back-n sender control for one peer
// Turns received ack sequence numbers into send commands for the packet
// builder.
// ----------------------------------------------------------------------------
// usage:
//   ack channel (ack_valid/ack_ready/ack_sequence) takes one ack word at a
//   time; ack_ready is high only while the sequencer is idle.
//   send channel (send_valid/send_ready) delivers the send commands an ack
//   causes, one word each, last_of_run set on the final one of the run.
//   an ack that matches no rule gives no word and frees the block again.
//   all sequence math goes through one 32-bit add/subtract unit, one
//   operation per cycle. a begin/fin/finished word is set in the decode
//   state, an end word in the end sequence state; a begin ack that opens
//   the window passes the window minimum state, a sliding window ack the
//   states w1 to w8, before the data sequence state builds a data word.
//   every following data word is built in the increment and data sequence
//   states after the previous one was taken. when the receiver stalls, the
//   held word stays on the outputs and the sequencer waits. reset clears
//   the window and flags and loads the register defaults; registers are to
//   be written over apb only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module sliding_window_ack_sender_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        ack_valid,
	output logic        ack_ready,
	input  logic [31:0] ack_sequence,
	output logic        send_valid,
	input  logic        send_ready,
	output logic [2:0]  send_kind,
	output logic [31:0] send_sequence,
	output logic [31:0] packet_index,
	output logic        last_of_run
);
	import swack_pkg::*;

	state_t state_q, state_d;

	logic [15:0] base_q;
	logic [31:0] last_cfg_q;
	logic        stored_q;
	logic [6:0]  window_cfg_q;

	logic        syn_acked_q;
	logic        begin_sent_q;
	logic [31:0] wbegin_q;
	logic [31:0] wend_q;

	logic [31:0] ack_q;
	logic [31:0] t1_q;
	logic [31:0] s_q;
	logic [31:0] lp1_q;
	logic [31:0] d_q;
	logic [31:0] tmp_q;
	logic [31:0] idx_q;
	logic [31:0] end_q;
	logic [CNT_W-1:0] cnt_q;

	logic [2:0]  out_kind_q;
	logic [31:0] out_seq_q;
	logic [31:0] out_idx_q;
	logic        out_last_q;

	logic [31:0] last_eff;
	logic [6:0]  win_eff;
	logic        cfg_wr;
	logic        dec_syn, dec_beg, dec_fin, dec_done, dec_end;

	alu_op_t     alu_op;
	logic [32:0] alu_sum;
	logic [31:0] alu_y;
	logic        alu_c;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			last_cfg_q   <= 32'd1;
			stored_q     <= 1'b0;
			window_cfg_q <= 7'd16;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BASE:   base_q       <= pwdata[15:0];
				REG_LAST:   last_cfg_q   <= pwdata;
				REG_STORED: stored_q     <= pwdata[0];
				REG_WINDOW: window_cfg_q <= pwdata[6:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BASE:   prdata = {16'd0, base_q};
			REG_LAST:   prdata = last_cfg_q;
			REG_STORED: prdata = {31'd0, stored_q};
			REG_WINDOW: prdata = {25'd0, window_cfg_q};
			default:    prdata = '0;
		endcase
	end

	// zero last index means one data packet, window clamped to 1..max
	assign last_eff = (last_cfg_q == 32'd0) ? 32'd1 : last_cfg_q;

	always_comb begin
		if (window_cfg_q == 7'd0)
			win_eff = 7'd1;
		else if (window_cfg_q > 7'(MAX_WINDOW))
			win_eff = 7'(MAX_WINDOW);
		else
			win_eff = window_cfg_q;
	end

	// ---------------------------------------------------------- shared unit
	// carry high on subtract means no borrow (a >= b)
	assign alu_sum = {1'b0, alu_op.a} + {1'b0, alu_op.sub ? ~alu_op.b : alu_op.b}
		+ {32'd0, alu_op.sub};
	assign alu_y   = alu_sum[31:0];
	assign alu_c   = alu_sum[32];

	// s is ack - base - 1, d is s - (last + 1)
	assign dec_syn  = !syn_acked_q && (s_q == 32'd0);
	assign dec_beg  = begin_sent_q && (s_q == 32'd1);
	assign dec_fin  = stored_q && (d_q == 32'd1);
	assign dec_done = stored_q && (d_q == 32'd2);
	assign dec_end  = stored_q && (d_q == 32'd0);

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (ack_valid) state_d = ST_T1;
			ST_T1:     state_d = ST_S;
			ST_S:      state_d = ST_LP1;
			ST_LP1:    state_d = ST_D;
			ST_D:      state_d = ST_DEC;
			ST_DEC: begin
				if (dec_syn)
					state_d = ST_OUT;
				else if (dec_beg)
					state_d = ST_WMIN;
				else if (dec_fin || dec_done)
					state_d = ST_OUT;
				else if (dec_end)
					state_d = ST_ENDSEQ;
				else if (begin_sent_q)
					state_d = ST_W1;
				else
					state_d = ST_IDLE;
			end
			ST_WMIN:   state_d = ST_DSEQ;
			ST_ENDSEQ: state_d = ST_OUT;
			ST_W1:     state_d = ST_W2;
			ST_W2:     state_d = alu_c ? ST_W3 : ST_IDLE;
			ST_W3:     state_d = ST_W4;
			ST_W4:     state_d = alu_c ? ST_W5 : ST_IDLE;
			ST_W5:     state_d = ST_W6;
			ST_W6:     state_d = ST_W7;
			ST_W7:     state_d = ST_W8;
			ST_W8:     state_d = alu_c ? ST_IDLE : ST_DSEQ;
			ST_DSEQ:   state_d = ST_OUT;
			ST_DINC:   state_d = ST_DSEQ;
			ST_OUT:    if (send_ready) state_d = out_last_q ? ST_IDLE : ST_DINC;
			default:   state_d = ST_IDLE;
		endcase
	end

	// -------------------------------------------------------------- outputs
	always_comb begin
		alu_op     = '{a: 32'd0, b: 32'd0, sub: 1'b0};
		ack_ready  = 1'b0;
		send_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:   ack_ready = 1'b1;
			ST_T1:     alu_op = '{a: {16'd0, base_q}, b: 32'd1, sub: 1'b0};
			ST_S:      alu_op = '{a: ack_q, b: t1_q, sub: 1'b1};
			ST_LP1:    alu_op = '{a: last_eff, b: 32'd1, sub: 1'b0};
			ST_D:      alu_op = '{a: s_q, b: lp1_q, sub: 1'b1};
			ST_WMIN:   alu_op = '{a: {25'd0, win_eff}, b: last_eff, sub: 1'b1};
			ST_ENDSEQ: alu_op = '{a: t1_q, b: lp1_q, sub: 1'b0};
			ST_W1:     alu_op = '{a: wbegin_q, b: 32'd1, sub: 1'b0};
			ST_W2:     alu_op = '{a: s_q, b: tmp_q, sub: 1'b1};
			ST_W3:     alu_op = '{a: wend_q, b: 32'd1, sub: 1'b0};
			ST_W4:     alu_op = '{a: idx_q, b: s_q, sub: 1'b1};
			ST_W5:     alu_op = '{a: s_q, b: {25'd0, win_eff}, sub: 1'b0};
			ST_W6:     alu_op = '{a: tmp_q, b: 32'd1, sub: 1'b1};
			ST_W7:     alu_op = '{a: tmp_q, b: last_eff, sub: 1'b1};
			ST_W8:     alu_op = '{a: wend_q, b: end_q, sub: 1'b1};
			ST_DSEQ:   alu_op = '{a: idx_q, b: t1_q, sub: 1'b0};
			ST_DINC:   alu_op = '{a: idx_q, b: 32'd1, sub: 1'b0};
			ST_OUT:    send_valid = 1'b1;
			default:   ;
		endcase
	end

	assign send_kind     = out_kind_q;
	assign send_sequence = out_seq_q;
	assign packet_index  = out_idx_q;
	assign last_of_run   = out_last_q;

	// ------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			syn_acked_q  <= 1'b0;
			begin_sent_q <= 1'b0;
			wbegin_q     <= '0;
			wend_q       <= '0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DEC: begin
					if (dec_syn) begin
						syn_acked_q  <= 1'b1;
						begin_sent_q <= 1'b1;
					end
				end
				ST_WMIN: begin
					// repeated begin ack restarts the window at 1
					wbegin_q <= 32'd1;
					wend_q   <= alu_c ? last_eff : {25'd0, win_eff};
					cnt_q    <= '0;
				end
				ST_W8: begin
					wbegin_q <= s_q;
					wend_q   <= end_q;
					cnt_q    <= '0;
				end
				ST_OUT: if (send_ready) cnt_q <= cnt_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- working values
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:   if (ack_valid) ack_q <= ack_sequence;
			ST_T1:     t1_q  <= alu_y;
			ST_S:      s_q   <= alu_y;
			ST_LP1:    lp1_q <= alu_y;
			ST_D:      d_q   <= alu_y;
			ST_DEC: begin
				if (dec_syn) begin
					out_kind_q <= KIND_BEGIN;
					out_seq_q  <= t1_q;
					out_idx_q  <= '0;
					out_last_q <= 1'b1;
				end else if (!dec_beg && dec_fin) begin
					out_kind_q <= KIND_FIN;
					out_seq_q  <= ack_q;
					out_idx_q  <= '0;
					out_last_q <= 1'b1;
				end else if (!dec_beg && dec_done) begin
					out_kind_q <= KIND_DONE;
					out_seq_q  <= '0;
					out_idx_q  <= '0;
					out_last_q <= 1'b1;
				end
			end
			ST_WMIN: begin
				idx_q <= 32'd1;
				end_q <= alu_c ? last_eff : {25'd0, win_eff};
			end
			ST_ENDSEQ: begin
				out_kind_q <= KIND_END;
				out_seq_q  <= alu_y;
				out_idx_q  <= lp1_q;
				out_last_q <= 1'b1;
			end
			ST_W1:     tmp_q <= alu_y;
			ST_W3:     idx_q <= alu_y;
			ST_W5:     tmp_q <= alu_y;
			ST_W6:     tmp_q <= alu_y;
			// new end is the smaller of candidate and last index
			ST_W7:     end_q <= alu_c ? last_eff : tmp_q;
			ST_DSEQ: begin
				out_kind_q <= KIND_DATA;
				out_seq_q  <= alu_y;
				out_idx_q  <= idx_q;
				out_last_q <= (idx_q == end_q) || (cnt_q == CNT_W'(MAX_WINDOW - 1));
			end
			ST_DINC:   idx_q <= alu_y;
			default:   ;
		endcase
	end

endmodule
